[design/ores_pkg.sv]
// Package for the 1-Wire ROM search engine: request codes, search limits,
// and the request and response transaction types. No dependencies.
`default_nettype none

package ores_pkg;

    // Request kinds
    localparam logic [2:0] REQ_RESET  = 3'd0;
    localparam logic [2:0] REQ_START  = 3'd1;
    localparam logic [2:0] REQ_BITS   = 3'd2;
    localparam logic [2:0] REQ_TARGET = 3'd3;
    localparam logic [2:0] REQ_SKIP   = 3'd4;

    // Search limits
    localparam int ROM_BITS     = 64;
    localparam int POS_W        = 7;
    localparam int FAMILY_LIMIT = 9;
    localparam int FAM_W        = 4;

    // Status codes
    localparam logic STATUS_OK      = 1'b0;
    localparam logic STATUS_IGNORED = 1'b1;

    typedef struct packed {
        logic [2:0] req_type;
        logic       presence_missing;
        logic       id_bit;
        logic       id_bit_comp;
        logic [7:0] fam_code;
    } t_req;

    typedef struct packed {
        logic                status;
        logic                send_command;
        logic                write_valid;
        logic                write_bit;
        logic                pass_end;
        logic                found;
        logic                last_device;
        logic [ROM_BITS-1:0] rom_code;
    } t_rsp;

endpackage

`default_nettype wire

[design/ores_core.sv]
// Search state and per-request update logic of the ROM search engine.
// Depends on ores_pkg for request codes and transaction types.
`default_nettype none

module ores_core (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_fire,
    input  wire ores_pkg::t_req i_req,
    output ores_pkg::t_rsp     o_rsp
);

    localparam int PW = ores_pkg::POS_W;
    localparam int FW = ores_pkg::FAM_W;
    localparam int RB = ores_pkg::ROM_BITS;
    localparam int IW = $clog2(RB);

    // Search state
    logic [RB-1:0] r_rom;
    logic [PW-1:0] r_last_disc;
    logic [FW-1:0] r_last_fam_disc;
    logic          r_last_dev;
    logic [PW-1:0] r_bit_pos;
    logic [PW-1:0] r_last_zero;
    logic          r_pass_active;

    logic [RB-1:0] n_rom;
    logic [PW-1:0] n_last_disc;
    logic [FW-1:0] n_last_fam_disc;
    logic          n_last_dev;
    logic [PW-1:0] n_bit_pos;
    logic [PW-1:0] n_last_zero;
    logic          n_pass_active;

    // Bit-pair helpers
    logic [PW-1:0] pos_m1;
    logic [IW-1:0] idx;
    logic          dir;
    ores_pkg::t_rsp rsp;

    assign pos_m1 = r_bit_pos - PW'(1);
    assign idx    = pos_m1[IW-1:0];

    // Branch direction from the discrepancy history
    always_comb begin
        if (i_req.id_bit != i_req.id_bit_comp) begin
            dir = i_req.id_bit;
        end else if (r_bit_pos < r_last_disc) begin
            dir = r_rom[idx];
        end else begin
            dir = (r_bit_pos == r_last_disc);
        end
    end

    // Next state and response for one request
    always_comb begin
        n_rom           = r_rom;
        n_last_disc     = r_last_disc;
        n_last_fam_disc = r_last_fam_disc;
        n_last_dev      = r_last_dev;
        n_bit_pos       = r_bit_pos;
        n_last_zero     = r_last_zero;
        n_pass_active   = r_pass_active;
        rsp             = '0;
        rsp.status      = ores_pkg::STATUS_OK;

        unique case (i_req.req_type)
            ores_pkg::REQ_RESET: begin
                n_last_disc     = '0;
                n_last_fam_disc = '0;
                n_last_dev      = 1'b0;
                n_pass_active   = 1'b0;
            end
            ores_pkg::REQ_START: begin
                n_pass_active = 1'b0;
                if (r_last_dev || i_req.presence_missing) begin
                    n_last_disc     = '0;
                    n_last_fam_disc = '0;
                    n_last_dev      = 1'b0;
                    rsp.pass_end    = 1'b1;
                end else begin
                    rsp.send_command = 1'b1;
                    n_pass_active    = 1'b1;
                    n_bit_pos        = PW'(1);
                    n_last_zero      = '0;
                end
            end
            ores_pkg::REQ_BITS: begin
                if (!r_pass_active) begin
                    rsp.status = ores_pkg::STATUS_IGNORED;
                end else if (i_req.id_bit && i_req.id_bit_comp) begin
                    // no device answered: abort the pass
                    n_last_disc     = '0;
                    n_last_fam_disc = '0;
                    n_last_dev      = 1'b0;
                    n_pass_active   = 1'b0;
                    rsp.pass_end    = 1'b1;
                end else begin
                    if ((i_req.id_bit == i_req.id_bit_comp) && !dir) begin
                        n_last_zero = r_bit_pos;
                        if (r_bit_pos < PW'(ores_pkg::FAMILY_LIMIT)) begin
                            n_last_fam_disc = r_bit_pos[FW-1:0];
                        end
                    end
                    n_rom[idx]      = dir;
                    rsp.write_valid = 1'b1;
                    rsp.write_bit   = dir;
                    n_bit_pos       = r_bit_pos + PW'(1);
                    // final bit of the ROM code
                    if (r_bit_pos >= PW'(RB)) begin
                        n_pass_active = 1'b0;
                        rsp.pass_end  = 1'b1;
                        n_last_disc   = n_last_zero;
                        if (n_last_zero == '0) begin
                            n_last_dev = 1'b1;
                        end
                        rsp.found = 1'b1;
                        if (n_rom[7:0] == 8'd0) begin
                            n_last_disc     = '0;
                            n_last_fam_disc = '0;
                            n_last_dev      = 1'b0;
                            rsp.found       = 1'b0;
                        end
                    end
                end
            end
            ores_pkg::REQ_TARGET: begin
                n_rom           = {{(RB-8){1'b0}}, i_req.fam_code};
                n_last_disc     = PW'(RB);
                n_last_fam_disc = '0;
                n_last_dev      = 1'b0;
                n_pass_active   = 1'b0;
            end
            ores_pkg::REQ_SKIP: begin
                n_last_disc     = PW'(r_last_fam_disc);
                n_last_fam_disc = '0;
                if (r_last_fam_disc == '0) begin
                    n_last_dev = 1'b1;
                end
                n_pass_active = 1'b0;
            end
            default: begin
                rsp.status = ores_pkg::STATUS_IGNORED;
            end
        endcase

        rsp.last_device = n_last_dev;
        rsp.rom_code    = n_rom;
    end

    assign o_rsp = rsp;

    // State update on each transaction
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rom           <= '0;
            r_last_disc     <= '0;
            r_last_fam_disc <= '0;
            r_last_dev      <= 1'b0;
            r_bit_pos       <= PW'(1);
            r_last_zero     <= '0;
            r_pass_active   <= 1'b0;
        end else if (i_fire) begin
            r_rom           <= n_rom;
            r_last_disc     <= n_last_disc;
            r_last_fam_disc <= n_last_fam_disc;
            r_last_dev      <= n_last_dev;
            r_bit_pos       <= n_bit_pos;
            r_last_zero     <= n_last_zero;
            r_pass_active   <= n_pass_active;
        end
    end

`ifndef NO_ASSERTIONS
    // A finished or aborted pass leaves no active pass
    a_end_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_fire && rsp.pass_end |=> !r_pass_active)
        else $error("pass still active after pass end");

    // A new pass starts at the first bit
    a_start_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_fire && rsp.send_command |=> r_pass_active && (r_bit_pos == PW'(1)))
        else $error("pass did not start at bit one");

    // During a pass the bit position stays within the ROM code
    a_pos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pass_active |-> (r_bit_pos != '0) && (r_bit_pos <= PW'(RB)))
        else $error("bit position out of range during pass");

    // A found device comes only with the final written bit
    a_found_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_fire && rsp.found |-> rsp.pass_end && rsp.write_valid)
        else $error("found reported without pass end");
`endif

endmodule

`default_nettype wire

[design/ores_out_reg.sv]
// Result register of the ROM search engine: holds one response transaction
// until the downstream side takes it. Depends on ores_pkg.
`default_nettype none

module ores_out_reg (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_load,
    input  wire ores_pkg::t_rsp i_rsp,
    input  wire logic           i_stall,
    output logic                o_free,
    output logic                o_valid,
    output ores_pkg::t_rsp      o_rsp
);

    logic           r_valid;
    ores_pkg::t_rsp r_rsp;

    // Register can take a new response when empty or being drained
    assign o_free  = !r_valid || !i_stall;
    assign o_valid = r_valid;
    assign o_rsp   = r_rsp;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (!i_stall) begin
            r_valid <= 1'b0;
        end
    end

    // Payload
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_rsp <= i_rsp;
        end
    end

endmodule

`default_nettype wire

[design/onewire_rom_search_engine_unit.sv]
// An accepted request is held in the input register, then its search update is
// registered into the result register together with the new search state.
// Throughput: one request per cycle while the output is not stalled.
// Reset (i_rst_n, synchronous, active low): ROM register and discrepancy state
// cleared, bit position one, no pass active, both registers empty.
`default_nettype none

module onewire_rom_search_engine_unit (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_valid,
    output logic                o_stall,
    input  wire ores_pkg::t_req i_req,
    output logic                o_valid,
    input  wire logic           i_stall,
    output ores_pkg::t_rsp      o_rsp
);

    logic           r_in_valid;
    ores_pkg::t_req r_in_req;
    logic           out_free;
    logic           advance;
    ores_pkg::t_rsp core_rsp;

    // Input register moves forward when the result register has room
    assign advance = r_in_valid && out_free;
    assign o_stall = r_in_valid && !out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_stall) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && !o_stall) begin
            r_in_req <= i_req;
        end
    end

    // Search state and update
    ores_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (advance),
        .i_req   (r_in_req),
        .o_rsp   (core_rsp)
    );

    // Result register
    ores_out_reg u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (advance),
        .i_rsp   (core_rsp),
        .i_stall (i_stall),
        .o_free  (out_free),
        .o_valid (o_valid),
        .o_rsp   (o_rsp)
    );

endmodule

`default_nettype wire
